@@ src/sdve_pkg.sv @@
`timescale 1ns / 1ps

package sdve_pkg;

	localparam int OFFSET_BITS = 40;
	localparam int LEN_W = 19;
	localparam int VAL_W = OFFSET_BITS + 1;
	localparam int IN_TDATA_W = 64;
	localparam int OUT_TDATA_W = 8;
	localparam int VARINT_BITS = 7;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 40;
	localparam int SHIFT_W = 4;
	localparam int NSTR_W = 9;

	localparam logic [LEN_W-1:0] SEG_CAP = LEN_W'(262144);
	localparam logic [SHIFT_W-1:0] MAX_SHIFT = SHIFT_W'(12);
	localparam int JOIN_SLACK = 64;

	localparam logic [OFFSET_BITS-1:0] BLOB_RESET = OFFSET_BITS'(64'd2147483648);
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(6);
	localparam logic [NSTR_W-1:0] NSTR_RESET = NSTR_W'(4);

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STORE_SIZE = 2'd0,
		REG_ALIGN_SHIFT = 2'd1,
		REG_NUM_STREAMS = 2'd2
	} cfg_reg_t;

	// One varint to be serialized, with the flags for its final byte.
	typedef struct packed {
		logic [VAL_W-1:0] val;
		logic eof;
		logic last;
	} cmd_t;

endpackage

@@ src/sdve_ram.sv @@
`timescale 1ns / 1ps

module sdve_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 256,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/sdve_front.sv @@
`timescale 1ns / 1ps

module sdve_front import sdve_pkg::*; #(
	parameter int MAX_STREAMS = 256,
	parameter int SID_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [OFFSET_BITS-1:0] seg_offset,
	input  logic [LEN_W-1:0] seg_length,
	input  logic frame_first,
	input  logic frame_last,
	input  logic cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cmd_t cmd,
	output logic cmd_valid,
	input  logic cmd_ready,
	output logic mem_we,
	output logic [SID_W-1:0] mem_waddr,
	output logic [OFFSET_BITS-1:0] mem_wdata,
	output logic [SID_W-1:0] mem_raddr,
	input  logic [OFFSET_BITS-1:0] mem_rdata
);

	localparam int CW = ((SID_W > NSTR_W) ? SID_W : NSTR_W) + 1;
	localparam int EW = VAL_W + 1;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_FIT, ST_CLAMP, ST_FL_ZZ, ST_FL_LEN,
		ST_SID, ST_RDW, ST_MRG_A, ST_MRG_B, ST_MRG_C, ST_LOAD
	} state_t;

	typedef enum logic [1:0] {FK_HEAD, FK_MID, FK_TAIL} flush_kind_t;

	state_t state_q;
	flush_kind_t kind_q;

	logic [OFFSET_BITS-1:0] blob_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [NSTR_W-1:0] nstr_q;

	logic [OFFSET_BITS-1:0] off_q, po_q, pl_q, rp_q;
	logic [LEN_W-1:0] len_q;
	logic first_q, last_q, pv_q, enc_q;
	logic [SID_W-1:0] rr_q, cur_q, clr_q;
	logic [VAL_W-1:0] pend_end_q, new_end_q;

	logic [SHIFT_W-1:0] shift_eff;
	logic [LEN_W-1:0] unit, lmask, len_cap, len_al, len_sh;
	logic [OFFSET_BITS-1:0] blob_eff, omask, off_al, ref_v, len_units;
	logic [VAL_W-1:0] diff, zz, fit_sum;
	logic over, merge, grow;
	logic [NSTR_W-1:0] ns_eff;
	logic [CW-1:0] rr_w, ns_w, sid_w, sid_inc;
	logic [SID_W-1:0] sid, rr_nxt;
	state_t shaped_next, tail_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blob_q <= BLOB_RESET;
			shift_q <= SHIFT_RESET;
			nstr_q <= NSTR_RESET;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_STORE_SIZE: blob_q <= cfg_data[OFFSET_BITS-1:0];
				REG_ALIGN_SHIFT: shift_q <= cfg_data[SHIFT_W-1:0];
				REG_NUM_STREAMS: nstr_q <= cfg_data[NSTR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		shift_eff = (shift_q > MAX_SHIFT) ? MAX_SHIFT : shift_q;
		unit = LEN_W'(1) << shift_eff;
		lmask = unit - LEN_W'(1);
		omask = ~OFFSET_BITS'(lmask);
		blob_eff = (blob_q == '0) ? OFFSET_BITS'(1) : blob_q;

		len_cap = (seg_length > SEG_CAP) ? SEG_CAP : seg_length;
		len_al = len_cap & ~lmask;
		len_sh = (len_al < unit) ? unit : len_al;
		off_al = seg_offset & omask;

		fit_sum = {1'b0, off_q} + VAL_W'(len_q);
		over = fit_sum > {1'b0, blob_eff};

		ref_v = (!enc_q && rp_q == '0) ? (blob_eff >> 1) : rp_q;
		diff = {1'b0, po_q} - {1'b0, ref_v};
		zz = diff[VAL_W-1] ? {~diff[OFFSET_BITS-1:0], 1'b1} : {diff[OFFSET_BITS-1:0], 1'b0};
		len_units = pl_q >> shift_eff;

		merge = pv_q && (EW'(off_q) <= EW'(pend_end_q) + EW'(JOIN_SLACK));
		grow = new_end_q > pend_end_q;

		ns_eff = (nstr_q == '0 || 32'(nstr_q) > MAX_STREAMS) ? NSTR_W'(1) : nstr_q;
		rr_w = CW'(rr_q);
		ns_w = CW'(ns_eff);
		sid_w = (rr_w >= ns_w) ? '0 : rr_w;
		sid_inc = sid_w + CW'(1);
		sid = sid_w[SID_W-1:0];
		rr_nxt = (sid_inc >= ns_w) ? '0 : sid_inc[SID_W-1:0];

		if (first_q) begin
			shaped_next = pv_q ? ST_FL_ZZ : ST_SID;
		end else begin
			shaped_next = ST_MRG_A;
		end
		tail_next = last_q ? ST_FL_ZZ : ST_IDLE;
	end

	always_comb begin
		cmd_valid = 1'b0;
		cmd.val = zz;
		cmd.eof = 1'b0;
		cmd.last = 1'b0;
		case (state_q)
			ST_FL_ZZ: begin
				cmd_valid = 1'b1;
			end
			ST_FL_LEN: begin
				cmd_valid = 1'b1;
				cmd.val = {1'b0, len_units};
				cmd.eof = (kind_q != FK_MID);
				cmd.last = (kind_q == FK_TAIL) || (kind_q == FK_MID && !last_q);
			end
			ST_SID: begin
				cmd_valid = 1'b1;
				cmd.val = VAL_W'(sid);
				cmd.last = !last_q;
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	assign mem_we = (state_q == ST_CLEAR) ||
		(state_q == ST_FL_LEN && cmd_ready && kind_q != FK_MID);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : cur_q;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : rp_q;
	assign mem_raddr = sid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			kind_q <= FK_HEAD;
			clr_q <= '0;
			pv_q <= 1'b0;
			enc_q <= 1'b0;
			rr_q <= '0;
			cur_q <= '0;
			rp_q <= '0;
			po_q <= '0;
			pl_q <= '0;
			off_q <= '0;
			len_q <= '0;
			pend_end_q <= '0;
			new_end_q <= '0;
			first_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SID_W'(1);
					if (clr_q == SID_W'(MAX_STREAMS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						off_q <= off_al;
						len_q <= len_sh;
						first_q <= frame_first;
						last_q <= frame_last;
						state_q <= ST_FIT;
					end
				end
				ST_FIT: begin
					kind_q <= FK_HEAD;
					if (over) begin
						if (OFFSET_BITS'(len_q) > blob_eff) begin
							len_q <= blob_eff[LEN_W-1:0];
						end
						state_q <= ST_CLAMP;
					end else begin
						state_q <= shaped_next;
					end
				end
				ST_CLAMP: begin
					off_q <= (blob_eff - OFFSET_BITS'(len_q)) & omask;
					state_q <= shaped_next;
				end
				ST_FL_ZZ: begin
					if (cmd_ready) begin
						rp_q <= po_q;
						enc_q <= 1'b1;
						state_q <= ST_FL_LEN;
					end
				end
				ST_FL_LEN: begin
					if (cmd_ready) begin
						pv_q <= 1'b0;
						case (kind_q)
							FK_HEAD: begin
								enc_q <= 1'b0;
								state_q <= ST_SID;
							end
							FK_MID: begin
								state_q <= ST_LOAD;
							end
							default: begin
								enc_q <= 1'b0;
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SID: begin
					if (cmd_ready) begin
						rr_q <= rr_nxt;
						cur_q <= sid;
						enc_q <= 1'b0;
						state_q <= ST_RDW;
					end
				end
				ST_RDW: begin
					rp_q <= mem_rdata;
					state_q <= ST_MRG_A;
				end
				ST_MRG_A: begin
					pend_end_q <= {1'b0, po_q} + {1'b0, pl_q};
					new_end_q <= {1'b0, off_q} + VAL_W'(len_q);
					state_q <= ST_MRG_B;
				end
				ST_MRG_B: begin
					if (merge) begin
						kind_q <= FK_TAIL;
						state_q <= grow ? ST_MRG_C : tail_next;
					end else if (pv_q) begin
						kind_q <= FK_MID;
						state_q <= ST_FL_ZZ;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_MRG_C: begin
					pl_q <= OFFSET_BITS'(new_end_q - {1'b0, po_q});
					state_q <= tail_next;
				end
				ST_LOAD: begin
					pv_q <= 1'b1;
					po_q <= off_q;
					pl_q <= OFFSET_BITS'(len_q);
					kind_q <= FK_TAIL;
					state_q <= tail_next;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ src/sdve_queue.sv @@
`timescale 1ns / 1ps

module sdve_queue import sdve_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t out_data
);

	cmd_t slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q, rd_q;
	logic [QUEUE_AW:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != (QUEUE_AW + 1)'(QUEUE_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data = slots_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QUEUE_AW + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QUEUE_AW + 1)'(1);
			end
		end
	end

endmodule

@@ src/sdve_back.sv @@
`timescale 1ns / 1ps

module sdve_back import sdve_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic out_valid,
	input  logic out_ready,
	output logic [OUT_TDATA_W-1:0] out_byte,
	output logic end_of_frame,
	output logic last
);

	logic [VAL_W-1:0] val_q;
	logic busy_q, eof_q, last_q;
	logic more;

	assign more = |val_q[VAL_W-1:VARINT_BITS];
	assign out_valid = busy_q;
	assign out_byte = {more, val_q[VARINT_BITS-1:0]};
	assign end_of_frame = eof_q && !more;
	assign last = last_q && !more;
	assign cmd_ready = !busy_q || (out_ready && !more);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			val_q <= '0;
			eof_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				val_q <= cmd.val;
				eof_q <= cmd.eof;
				last_q <= cmd.last;
				busy_q <= 1'b1;
			end else if (busy_q && out_ready) begin
				if (more) begin
					val_q <= val_q >> VARINT_BITS;
				end else begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

@@ src/segment_delta_varint_encoder.sv @@
`timescale 1ns / 1ps

// Segment encoder: segments come in on the s_axis channel, one item each, and the
// encoded byte stream leaves on the m_axis channel, one byte per item.
// Registers are written on the cfg channel, which is always ready; write them only
// while no item is in flight.
// The front part shapes each segment, merges it with the pending one or flushes
// that one, and turns the work into varint commands in a four-entry queue. The back
// part serializes each command at one byte per cycle while m_axis is ready, so the
// sustained rate is one output byte per cycle while commands are queued; items
// pass the front one at a time, and the front waits while the queue is full.
// A segment's offset goes out when a later item or the frame's last item flushes it.
// After reset the per-stream offset memory is cleared, one entry per cycle, over all
// MAX_STREAMS entries; s_axis_tready stays low during that pass.
// When m_axis stalls, the back part holds its byte, the queue fills and then the
// front part waits; no byte is lost or repeated.
module segment_delta_varint_encoder import sdve_pkg::*; #(
	parameter int MAX_STREAMS = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// seg_offset [39:0], seg_length [58:40], zero [63:59]
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,
	// frame_last
	input  logic s_axis_tlast,
	// frame_first
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// out_byte [7:0]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// end_of_frame
	output logic m_axis_tlast,
	// last
	output logic m_axis_tuser,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SID_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;

	cmd_t fq_data, qb_data;
	logic fq_valid, fq_ready, qb_valid, qb_ready;
	logic mem_we;
	logic [SID_W-1:0] mem_waddr, mem_raddr;
	logic [OFFSET_BITS-1:0] mem_wdata, mem_rdata;

	assign cfg_ready = 1'b1;

	sdve_front #(
		.MAX_STREAMS(MAX_STREAMS),
		.SID_W(SID_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.seg_offset(s_axis_tdata[OFFSET_BITS-1:0]),
		.seg_length(s_axis_tdata[OFFSET_BITS+LEN_W-1:OFFSET_BITS]),
		.frame_first(s_axis_tuser),
		.frame_last(s_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(fq_data),
		.cmd_valid(fq_valid),
		.cmd_ready(fq_ready),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	sdve_ram #(
		.WIDTH(OFFSET_BITS),
		.DEPTH(MAX_STREAMS),
		.AW(SID_W)
	) u_prev_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	sdve_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(fq_valid),
		.in_ready(fq_ready),
		.in_data(fq_data),
		.out_valid(qb_valid),
		.out_ready(qb_ready),
		.out_data(qb_data)
	);

	sdve_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(qb_valid),
		.cmd_ready(qb_ready),
		.cmd(qb_data),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_byte(m_axis_tdata),
		.end_of_frame(m_axis_tlast),
		.last(m_axis_tuser)
	);

endmodule

@@ src/sdve_checker.sv @@
`timescale 1ns / 1ps

module sdve_checker import sdve_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic m_axis_tlast,
	input logic m_axis_tuser
);

	// A stalled output byte stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output byte changed while stalled");

	// The final byte of a frame ends a varint.
	a_eof_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[OUT_TDATA_W-1])
		else $error("end of frame on a continued varint");

	// The final byte of an item ends a varint.
	a_last_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[OUT_TDATA_W-1])
		else $error("item end on a continued varint");

	// Items are taken one at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in work");

endmodule

bind segment_delta_varint_encoder sdve_checker u_checker (.*);

@@ bench/sdve_checker.sv @@
`timescale 1ns / 1ps

module sdve_monitor import sdve_pkg::*; #(
	parameter int MAX_STREAMS = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	// seg_offset [39:0], seg_length [58:40], zero [63:59]
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,
	// frame_last
	input  logic s_axis_tlast,
	// frame_first
	input  logic s_axis_tuser,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	// out_byte [7:0]
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// end_of_frame
	input  logic m_axis_tlast,
	// last
	input  logic m_axis_tuser,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned fail_count,
	output int unsigned outstanding,
	output int unsigned items_seen,
	output int unsigned bytes_seen,
	output int unsigned frames_seen,
	output int unsigned quiet_seen
);

	typedef struct packed {
		logic [OUT_TDATA_W-1:0] data;
		logic eof;
		logic fin;
	} enc_byte_t;

	enc_byte_t expected_bytes[$];
	enc_byte_t item_bytes[$];

	logic [OFFSET_BITS-1:0] store_reg;
	logic [SHIFT_W-1:0] align_shift;
	logic [NSTR_W-1:0] num_streams;

	logic [OFFSET_BITS-1:0] stream_offset[MAX_STREAMS];
	logic [7:0] rr_next;
	logic [7:0] cur_stream;
	logic [OFFSET_BITS-1:0] last_offset;
	logic in_frame;
	logic seg_held;
	logic [OFFSET_BITS-1:0] seg_offset;
	logic [OFFSET_BITS-1:0] seg_length;

	int unsigned fails;
	int unsigned n_items;
	int unsigned n_bytes;
	int unsigned n_frames;
	int unsigned n_quiet;

	task automatic report_mismatch(string msg);
		fails++;
		if (fails <= 100)
			$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	function automatic logic [63:0] store_size();
		return (store_reg == '0) ? 64'd1 : 64'(store_reg);
	endfunction

	function automatic int unsigned unit_log2();
		return (align_shift > MAX_SHIFT) ? int'(MAX_SHIFT) : int'(align_shift);
	endfunction

	function automatic void emit_varint(logic [63:0] v);
		while (v >= 64'h80) begin
			item_bytes.push_back(enc_byte_t'{data: {1'b1, v[6:0]}, eof: 1'b0, fin: 1'b0});
			v = v >> 7;
		end
		item_bytes.push_back(enc_byte_t'{data: v[7:0], eof: 1'b0, fin: 1'b0});
	endfunction

	function automatic void emit_segment();
		logic [63:0] anchor;
		logic [63:0] zz;
		if (!seg_held)
			return;
		anchor = (!in_frame && last_offset == '0) ? (store_size() >> 1) : 64'(last_offset);
		if (64'(seg_offset) >= anchor)
			zz = (64'(seg_offset) - anchor) << 1;
		else
			zz = ((anchor - 64'(seg_offset)) << 1) - 64'd1;
		emit_varint(zz);
		emit_varint(64'(seg_length) >> unit_log2());
		last_offset = seg_offset;
		in_frame = 1'b1;
		seg_held = 1'b0;
	endfunction

	function automatic void end_frame();
		enc_byte_t tail;
		if (!seg_held)
			return;
		emit_segment();
		tail = item_bytes.pop_back();
		tail.eof = 1'b1;
		item_bytes.push_back(tail);
		stream_offset[cur_stream] = last_offset;
		in_frame = 1'b0;
	endfunction

	function automatic void encode_item(logic [63:0] off, logic [63:0] len, logic first,
			logic closing);
		int unsigned ns;
		int unsigned sid;
		logic [63:0] unit;
		logic [63:0] blob;
		enc_byte_t tail;
		unit = 64'd1 << unit_log2();
		blob = store_size();
		item_bytes.delete();
		if (first) begin
			ns = (num_streams == '0 || num_streams > MAX_STREAMS) ? 1 : int'(num_streams);
			end_frame();
			sid = (rr_next >= ns) ? 0 : rr_next;
			rr_next = 8'((sid + 1 >= ns) ? 0 : sid + 1);
			cur_stream = 8'(sid);
			last_offset = stream_offset[sid];
			in_frame = 1'b0;
			emit_varint(64'(sid));
		end
		if (len > 64'(SEG_CAP))
			len = 64'(SEG_CAP);
		len &= ~(unit - 64'd1);
		if (len < unit)
			len = unit;
		off &= ~(unit - 64'd1);
		if (off + len > blob) begin
			if (len > blob)
				len = blob;
			off = (blob - len) & ~(unit - 64'd1);
		end
		if (seg_held && off <= 64'(seg_offset) + 64'(seg_length) + 64'(JOIN_SLACK)) begin
			if (off + len > 64'(seg_offset) + 64'(seg_length))
				seg_length = OFFSET_BITS'(off + len - 64'(seg_offset));
		end else begin
			emit_segment();
			seg_held = 1'b1;
			seg_offset = OFFSET_BITS'(off);
			seg_length = OFFSET_BITS'(len);
		end
		if (closing)
			end_frame();
		if (item_bytes.size() == 0) begin
			n_quiet++;
		end else begin
			tail = item_bytes.pop_back();
			tail.fin = 1'b1;
			item_bytes.push_back(tail);
			foreach (item_bytes[i])
				expected_bytes.push_back(item_bytes[i]);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		enc_byte_t want;
		if (!arst_n) begin
			store_reg = BLOB_RESET;
			align_shift = SHIFT_RESET;
			num_streams = NSTR_RESET;
			for (int i = 0; i < MAX_STREAMS; i++)
				stream_offset[i] = '0;
			rr_next = '0;
			cur_stream = '0;
			last_offset = '0;
			in_frame = 1'b0;
			seg_held = 1'b0;
			seg_offset = '0;
			seg_length = '0;
			expected_bytes.delete();
			fails = 0;
			n_items = 0;
			n_bytes = 0;
			n_frames = 0;
			n_quiet = 0;
		end else begin
			// Output bytes are matched before the new item is predicted, since no byte can
			// leave in the same cycle as the item that causes it.
			if (m_axis_tvalid && m_axis_tready) begin
				n_bytes++;
				if (m_axis_tlast)
					n_frames++;
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("byte %0d (0x%02h) arrived with none expected",
						n_bytes, m_axis_tdata));
				end else begin
					want = expected_bytes.pop_front();
					if (m_axis_tdata !== want.data)
						report_mismatch($sformatf("byte %0d out_byte 0x%02h, expected 0x%02h",
							n_bytes, m_axis_tdata, want.data));
					if (m_axis_tlast !== want.eof)
						report_mismatch($sformatf("byte %0d end_of_frame %b, expected %b",
							n_bytes, m_axis_tlast, want.eof));
					if (m_axis_tuser !== want.fin)
						report_mismatch($sformatf("byte %0d last %b, expected %b",
							n_bytes, m_axis_tuser, want.fin));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_STORE_SIZE: store_reg = cfg_data[OFFSET_BITS-1:0];
					REG_ALIGN_SHIFT: align_shift = cfg_data[SHIFT_W-1:0];
					REG_NUM_STREAMS: num_streams = cfg_data[NSTR_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				n_items++;
				encode_item(64'(s_axis_tdata[OFFSET_BITS-1:0]),
					64'(s_axis_tdata[OFFSET_BITS+LEN_W-1:OFFSET_BITS]),
					s_axis_tuser, s_axis_tlast);
			end
		end
		fail_count <= fails;
		outstanding <= expected_bytes.size();
		items_seen <= n_items;
		bytes_seen <= n_bytes;
		frames_seen <= n_frames;
		quiet_seen <= n_quiet;
	end

endmodule

@@ bench/segment_delta_varint_encoder_test.sv @@
`timescale 1ns / 1ps

module segment_delta_varint_encoder_test;
	import sdve_pkg::*;

	localparam int STREAM_SLOTS = 256;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata;
	logic s_axis_tlast;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;
	logic m_axis_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned items_seen;
	int unsigned bytes_seen;
	int unsigned frames_seen;
	int unsigned quiet_seen;

	bit tx_gaps;
	bit rx_gaps;
	logic [63:0] cur_blob;
	logic [63:0] seg_end;

	segment_delta_varint_encoder #(.MAX_STREAMS(STREAM_SLOTS)) dut (.*);

	sdve_monitor #(.MAX_STREAMS(STREAM_SLOTS)) check (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		m_axis_tready = 1'b0;
		@(posedge clk);
		forever begin
			if (rx_gaps && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		int unsigned idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("Timeout: nothing moved for %0d cycles", STALL_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_item(logic [63:0] off, logic [63:0] len, logic first, logic closing);
		if (tx_gaps && $urandom_range(0, 2) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_TDATA_W'({len[LEN_W-1:0], off[OFFSET_BITS-1:0]});
		s_axis_tuser <= first;
		s_axis_tlast <= closing;
		do @(posedge clk); while (!s_axis_tready);
		seg_end = off + len;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(logic [63:0] blob, logic [63:0] shift, logic [63:0] nstr);
		cfg_reg_t regs[3];
		logic [CFG_DATA_W-1:0] vals[3];
		regs = '{REG_STORE_SIZE, REG_ALIGN_SHIFT, REG_NUM_STREAMS};
		vals = '{CFG_DATA_W'(blob), CFG_DATA_W'(shift), CFG_DATA_W'(nstr)};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		cur_blob = (blob[OFFSET_BITS-1:0] == '0) ? 64'd1 : 64'(blob[OFFSET_BITS-1:0]);
	endtask

	function automatic logic [63:0] pick_offset();
		logic [63:0] wide;
		logic [63:0] off;
		wide = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: off = 64'd0;
			1: off = 64'({OFFSET_BITS{1'b1}});
			2, 3: off = wide & 64'({OFFSET_BITS{1'b1}});
			default: off = wide % cur_blob;
		endcase
		return off;
	endfunction

	function automatic logic [63:0] pick_length();
		logic [63:0] len;
		case ($urandom_range(0, 9))
			0: len = 64'd0;
			1: len = 64'({LEN_W{1'b1}});
			2: len = 64'(SEG_CAP);
			3: len = 64'($urandom_range(0, (1 << LEN_W) - 1));
			4: len = 64'($urandom_range(1, 64));
			default: len = 64'($urandom_range(1, 4096));
		endcase
		return len;
	endfunction

	function automatic logic [63:0] next_offset();
		logic [63:0] off;
		case ($urandom_range(0, 4))
			0, 1: off = seg_end + 64'($urandom_range(0, 96));
			2: off = seg_end - 64'($urandom_range(0, 256));
			default: off = pick_offset();
		endcase
		return off;
	endfunction

	task automatic run_phase(logic [63:0] blob, logic [63:0] shift, logic [63:0] nstr,
			int unsigned count, bit gaps_in, bit gaps_out, int unsigned pause_at);
		int unsigned sent;
		int unsigned k;
		drain();
		configure(blob, shift, nstr);
		tx_gaps = gaps_in;
		rx_gaps = gaps_out;
		sent = 0;
		while (sent < count) begin
			if (pause_at != 0 && sent >= pause_at) begin
				drain();
				pause_at = 0;
			end
			if ($urandom_range(0, 9) < 8) begin
				k = $urandom_range(1, 8);
				for (int j = 0; j < k; j++)
					send_item((j == 0) ? pick_offset() : next_offset(), pick_length(),
						j == 0, j == k - 1);
				sent += k;
			end else begin
				send_item(pick_offset(), pick_length(), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		s_axis_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_STORE_SIZE;
		cfg_data = '0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		cur_blob = 64'(BLOB_RESET);
		seg_end = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);

		// Reset register values: 2 GiB store, 64-byte units, four streams.
		send_item(64'h1000, 64'd1, 1'b1, 1'b0);
		send_item(64'h1080, 64'd300, 1'b0, 1'b0);
		send_item(64'h1200, 64'd64, 1'b0, 1'b0);
		send_item(64'hFF_FFFF_FFFF, 64'h7FFFF, 1'b0, 1'b1);
		send_item(64'h0, 64'h0, 1'b0, 1'b0);
		send_item(64'h5000, 64'(SEG_CAP), 1'b1, 1'b1);
		send_item(64'h4000_0000, 64'd64, 1'b1, 1'b0);
		send_item(64'h4000_0040, 64'd64, 1'b0, 1'b1);
		send_item(64'h100, 64'd128, 1'b1, 1'b1);
		send_item(64'h1000, 64'd64, 1'b1, 1'b0);
		send_item(64'h0, 64'd64, 1'b0, 1'b0);
		send_item(64'h7F_FFFF_0000, 64'd4096, 1'b0, 1'b1);
		send_item(64'h2000, 64'd64, 1'b1, 1'b0);
		send_item(64'h3000, 64'd64, 1'b0, 1'b0);
		send_item(64'h3000, 64'd64, 1'b0, 1'b0);
		send_item(64'h3081, 64'd64, 1'b1, 1'b1);
		send_item(64'h0, 64'd64, 1'b1, 1'b0);
		send_item(64'h10000, 64'd64, 1'b0, 1'b1);

		run_phase(64'd1, 64'd0, 64'd1, 30, 1'b1, 1'b0, 0);
		run_phase(64'({8'($urandom_range(0, 255)), $urandom}), 64'($urandom_range(0, 12)),
			64'd4, 80, 1'b1, 1'b1, 0);
		run_phase(64'({OFFSET_BITS{1'b1}}), 64'd12, 64'd256, 80, 1'b0, 1'b1, 0);
		run_phase(64'd0, 64'd15, 64'd0, 30, 1'b0, 1'b0, 0);
		run_phase(64'($urandom_range(1 << 20, 1 << 30)), 64'd13, 64'd300, 40, 1'b1, 1'b1, 0);
		run_phase(64'(BLOB_RESET), 64'($urandom_range(0, 12)), 64'd3, 60, 1'b1, 1'b1, 30);
		run_phase(64'({8'($urandom_range(0, 3)), $urandom}), 64'($urandom_range(0, 12)),
			64'($urandom_range(1, 16)), 130, 1'b0, 1'b0, 0);
		drain();

		$display("Run: %0d segment items, %0d encoded bytes, %0d frames closed, %0d silent items.",
			items_seen, bytes_seen, frames_seen, quiet_seen);
		$display("Settings went from a one-byte store to the full 40-bit one, units of 1 to 4096 bytes,");
		$display("1 to 256 streams and out-of-range register values.");
		if (fail_count == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ files.f @@
src/sdve_pkg.sv
src/sdve_ram.sv
src/sdve_front.sv
src/sdve_queue.sv
src/sdve_back.sv
src/segment_delta_varint_encoder.sv
src/sdve_checker.sv
bench/sdve_checker.sv
bench/segment_delta_varint_encoder_test.sv
